// ===== hdl/slid_pkg.sv =====
// Shared types and constants for the sorted list insert/delete core.
package slid_pkg;

  localparam int WORD_W       = 32;
  localparam int CAPACITY_DEF = 16;
  localparam int STATUS_W     = 2;
  localparam int COUNT_W      = 5;

  typedef enum logic [0:0] {
    ACT_INSERT = 1'b0,
    ACT_DELETE = 1'b1
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // Outcome of comparing a stored entry against the command key.
  typedef struct packed {
    logic lt;
    logic eq;
    logic gt;
  } cmp_res_t;

endpackage

// ===== hdl/sorted_list_insert_delete_core.sv =====
// Top level of the sorted list core: walk sequencer, entry count and result register.
//
// The core keeps up to CAPACITY signed 32-bit keys in ascending order in a
// single-port-write, registered-read memory. Each input word carries an action
// (insert or delete) and a key; each command yields exactly one result word
// holding a status and the entry count after the command.
// An insert walks downwards from the last entry, moving every larger entry up
// by one place, and drops the key in behind the last entry that is not larger,
// so equal keys keep their arrival order. A delete walks upwards from the
// first entry, finds the first equal key and closes the gap by moving every
// later entry down by one place.
// Timing: at most one memory read and one memory write per cycle through a single
// shared comparator. A command is shortest for an insert into a full store or a
// delete from an empty one and longest for a walk over the whole list; the result
// word is registered when the walk ends, and the next input word is taken once the
// core is idle and its output register is free. in_stall is high throughout a walk.
// Reset (synchronous, active low) empties the list and drops any pending
// result. If the receiver holds out_stall high, the result word waits in the
// output register; one further command may be accepted only once that word
// has been taken, so no result is ever overwritten.
module sorted_list_insert_delete_core #(
  parameter int CAPACITY = slid_pkg::CAPACITY_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [0:0]                           in_action,
  input  logic signed [slid_pkg::WORD_W-1:0]   in_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [slid_pkg::STATUS_W-1:0]        out_status,
  output logic [slid_pkg::COUNT_W-1:0]         out_entry_count
);
  import slid_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_INS  = 4'b0010,
    S_PUT  = 4'b0100,
    S_DEL  = 4'b1000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [AW-1:0]            idx_r, idx_nxt;
  logic                     found_r, found_nxt;
  logic signed [WORD_W-1:0] value_r, value_nxt;
  logic [CW-1:0]            count_r, count_nxt;

  logic                     out_valid_r, out_valid_nxt;
  status_t                  out_status_r, out_status_nxt;
  logic [CW-1:0]            out_count_r, out_count_nxt;

  // Memory port and comparator hookup.
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic signed [WORD_W-1:0] rd_data;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic signed [WORD_W-1:0] wr_data;
  cmp_res_t                 cr;

  // End of a command, with its result.
  logic                     fin;
  status_t                  fin_status;
  logic [CW-1:0]            fin_count;

  logic                     accept;
  logic                     hit;
  logic [AW-1:0]            last_idx;

  slid_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The read data always belongs to the entry at idx_r during a walk.
  slid_cmp u_cmp (
    .entry (rd_data),
    .key   (value_r),
    .res   (cr)
  );

  // A new word is only taken when idle and the result register is free or
  // being emptied in the same cycle.
  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign last_idx = AW'(count_r - 1'b1);
  assign hit      = found_r || cr.eq;

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    found_nxt  = found_r;
    value_nxt  = value_r;
    rd_en      = 1'b0;
    rd_addr    = idx_r;
    wr_en      = 1'b0;
    wr_addr    = idx_r;
    wr_data    = value_r;
    fin        = 1'b0;
    fin_status = ST_DONE;
    fin_count  = count_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          value_nxt = in_value;
          if (in_action == ACT_INSERT) begin
            if (count_r == CW'(CAPACITY)) begin
              fin        = 1'b1;
              fin_status = ST_FULL;
            end else if (count_r == '0) begin
              idx_nxt   = '0;
              state_nxt = S_PUT;
            end else begin
              // Start at the top entry and walk downwards.
              rd_en     = 1'b1;
              rd_addr   = last_idx;
              idx_nxt   = last_idx;
              state_nxt = S_INS;
            end
          end else begin
            if (count_r == '0) begin
              fin        = 1'b1;
              fin_status = ST_NOT_FOUND;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = '0;
              idx_nxt   = '0;
              found_nxt = 1'b0;
              state_nxt = S_DEL;
            end
          end
        end
      end

      S_INS: begin
        wr_en   = 1'b1;
        wr_addr = AW'(idx_r + 1'b1);
        if (cr.gt) begin
          // Larger entry moves up one place to open the gap.
          wr_data = rd_data;
          if (idx_r == '0) begin
            state_nxt = S_PUT;
          end else begin
            idx_nxt = AW'(idx_r - 1'b1);
            rd_en   = 1'b1;
            rd_addr = AW'(idx_r - 1'b1);
          end
        end else begin
          wr_data    = value_r;
          fin        = 1'b1;
          fin_status = ST_DONE;
          fin_count  = CW'(count_r + 1'b1);
          state_nxt  = S_IDLE;
        end
      end

      S_PUT: begin
        wr_en      = 1'b1;
        wr_addr    = idx_r;
        wr_data    = value_r;
        fin        = 1'b1;
        fin_status = ST_DONE;
        fin_count  = CW'(count_r + 1'b1);
        state_nxt  = S_IDLE;
      end

      S_DEL: begin
        if (found_r) begin
          // Close the gap: each later entry moves down one place.
          wr_en   = 1'b1;
          wr_addr = AW'(idx_r - 1'b1);
          wr_data = rd_data;
        end
        if (!found_r && cr.gt) begin
          fin        = 1'b1;
          fin_status = ST_NOT_FOUND;
          state_nxt  = S_IDLE;
        end else if (idx_r == last_idx) begin
          fin        = 1'b1;
          fin_status = hit ? ST_DONE : ST_NOT_FOUND;
          fin_count  = hit ? CW'(count_r - 1'b1) : count_r;
          state_nxt  = S_IDLE;
        end else begin
          found_nxt = hit;
          idx_nxt   = AW'(idx_r + 1'b1);
          rd_en     = 1'b1;
          rd_addr   = AW'(idx_r + 1'b1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    count_nxt      = fin ? fin_count : count_r;
    out_valid_nxt  = fin ? 1'b1 : (out_valid_r && out_stall);
    out_status_nxt = fin ? fin_status : out_status_r;
    out_count_nxt  = fin ? fin_count : out_count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      found_r     <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      found_r     <= found_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    value_r      <= value_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_count = COUNT_W'(out_count_r);

  // A write never lands past the first free place after the end of the list.
  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> ((CW+1)'(wr_addr) <= (CW+1)'(count_r)))
    else $error("entry write beyond end of list");

  // The entry count only moves when a command completes.
  a_count_on_fin: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(count_r) |-> $past(fin))
    else $error("entry count changed outside command completion");

  // A result is only produced when the output register can take it.
  a_fin_room: assert property (@(posedge clk) disable iff (!rst_n)
    fin |-> (!out_valid_r || !out_stall))
    else $error("result would overwrite a waiting word");

  // During a delete, entries move down only after the key was found.
  a_del_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEL && wr_en) |-> found_r)
    else $error("delete shifted entries before finding the key");

endmodule

// ===== hdl/slid_store.sv =====
// Entry memory: one write port and one registered read port.
module slid_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                               clk,
  input  logic                               wr_en,
  input  logic [AW-1:0]                      wr_addr,
  input  logic signed [slid_pkg::WORD_W-1:0] wr_data,
  input  logic                               rd_en,
  input  logic [AW-1:0]                      rd_addr,
  output logic signed [slid_pkg::WORD_W-1:0] rd_data
);
  import slid_pkg::*;

  logic signed [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/slid_cmp.sv =====
// Shared signed comparator used on every step of the list walk.
module slid_cmp (
  input  logic signed [slid_pkg::WORD_W-1:0] entry,
  input  logic signed [slid_pkg::WORD_W-1:0] key,
  output slid_pkg::cmp_res_t                 res
);
  import slid_pkg::*;

  always_comb begin
    res.lt = (entry < key);
    res.eq = (entry == key);
    res.gt = (entry > key);
  end

endmodule

// ===== bench/tb_sorted_list_insert_delete_core.sv =====
// Self-checking testbench for the sorted list insert/delete core.
module tb_sorted_list_insert_delete_core;
  timeunit 1ns;
  timeprecision 1ps;

  import slid_pkg::*;

  // The store is checked at its default size of sixteen entries, where the
  // five-bit entry count is exact.
  localparam int DEPTH        = CAPACITY_DEF;
  localparam int RANDOM_WORDS = 600;
  // A command walk is bounded by the depth of the store, and receiver stalls and
  // sender gaps are far shorter than QUIET_LIMIT, so a quiet stretch of that length
  // can only mean the core has hung.
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = DEPTH + 8;

  // One result word as the core should return it.
  typedef struct packed {
    status_t              status;
    logic [COUNT_W-1:0]   count;
  } result_t;

  // One row of the directed part. Where has_result is set, the result is typed
  // in by hand; otherwise it comes from the predictor like any random word.
  typedef struct packed {
    action_t              act;
    logic [WORD_W-1:0]    key;
    logic                 has_result;
    status_t              status;
    logic [COUNT_W-1:0]   count;
  } directed_row_t;

  // Receiver stall behaviour, switched every so often.
  typedef enum int {
    STALL_NONE,
    STALL_SPRINKLE,
    STALL_LONG
  } stall_mode_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [0:0]                 in_action = ACT_INSERT;
  logic signed [WORD_W-1:0]   in_value = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [STATUS_W-1:0]        out_status;
  logic [COUNT_W-1:0]         out_entry_count;

  // The predictor's own copy of the store: keys in ascending order and the
  // number of them that are live.
  logic signed [WORD_W-1:0]   list_keys [DEPTH];
  int                         list_count = 0;

  // Results the core still owes, oldest first.
  result_t                    pending_results [$];
  int                         mismatch_count = 0;
  int                         burst_left = 0;
  int                         quiet_cycles = 0;

  // The directed part. It opens on the empty store, goes through the extremes
  // of the key, equal keys and both refusals, then fills the store to the brim,
  // is turned away once and deletes one key before the random part takes over.
  directed_row_t directed_rows [25] = '{
    // Delete from the empty store: not found, count stays at zero.
    '{ACT_DELETE, 32'd5,          1'b1, ST_NOT_FOUND, 5'd0},
    '{ACT_INSERT, 32'd100,        1'b1, ST_DONE,      5'd1},
    // Delete of a key above every entry: not found, nothing moves.
    '{ACT_DELETE, 32'd200,        1'b1, ST_NOT_FOUND, 5'd1},
    '{ACT_INSERT, 32'h7fff_ffff,  1'b1, ST_DONE,      5'd2},
    '{ACT_INSERT, 32'h8000_0000,  1'b1, ST_DONE,      5'd3},
    // An equal key goes in behind the one already there.
    '{ACT_INSERT, 32'd100,        1'b0, ST_DONE,      5'd0},
    '{ACT_DELETE, 32'd100,        1'b0, ST_DONE,      5'd0},
    '{ACT_DELETE, 32'd100,        1'b0, ST_DONE,      5'd0},
    // Both copies are gone now, so a third delete must miss.
    '{ACT_DELETE, 32'd100,        1'b1, ST_NOT_FOUND, 5'd2},
    '{ACT_INSERT, 32'h0000_0000,  1'b0, ST_DONE,      5'd0},
    '{ACT_INSERT, 32'hffff_ffff,  1'b0, ST_DONE,      5'd0},
    '{ACT_INSERT, 32'h0000_0001,  1'b0, ST_DONE,      5'd0},
    '{ACT_INSERT, 32'haaaa_aaaa,  1'b0, ST_DONE,      5'd0},
    '{ACT_INSERT, 32'h5555_5555,  1'b0, ST_DONE,      5'd0},
    '{ACT_INSERT, 32'h0000_0000,  1'b0, ST_DONE,      5'd0},
    '{ACT_INSERT, 32'h0000_0000,  1'b0, ST_DONE,      5'd0},
    '{ACT_INSERT, 32'h7fff_ffff,  1'b0, ST_DONE,      5'd0},
    '{ACT_INSERT, 32'h8000_0000,  1'b0, ST_DONE,      5'd0},
    '{ACT_INSERT, 32'hffff_fffe,  1'b0, ST_DONE,      5'd0},
    '{ACT_INSERT, 32'h0001_0000,  1'b0, ST_DONE,      5'd0},
    '{ACT_INSERT, 32'h1234_5678,  1'b0, ST_DONE,      5'd0},
    '{ACT_INSERT, 32'hedcb_a987,  1'b0, ST_DONE,      5'd0},
    '{ACT_INSERT, 32'd42,         1'b1, ST_DONE,      5'd16},
    // Insert into the full store: refused, count stays at sixteen.
    '{ACT_INSERT, 32'd7,          1'b1, ST_FULL,      5'd16},
    // Delete the first of the two lowest keys from a full store.
    '{ACT_DELETE, 32'h8000_0000,  1'b1, ST_DONE,      5'd15}
  };

  sorted_list_insert_delete_core #(
    .CAPACITY (DEPTH)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Carries out one command on the predictor's copy of the store and returns
  // the result word it should produce. Keys are compared as signed values.
  function automatic result_t apply_command(action_t act, logic signed [WORD_W-1:0] key);
    int      pos;
    result_t res;
    pos = 0;
    if (act == ACT_INSERT) begin
      if (list_count >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        // Step past every entry that is not larger, so equal keys keep order.
        while (pos < list_count && list_keys[pos] <= key) pos++;
        for (int k = list_count; k > pos; k--) list_keys[k] = list_keys[k-1];
        list_keys[pos] = key;
        list_count++;
        res.status = ST_DONE;
      end
    end else begin
      while (pos < list_count && list_keys[pos] < key) pos++;
      if (pos >= list_count || list_keys[pos] != key) begin
        res.status = ST_NOT_FOUND;
      end else begin
        for (int k = pos; k + 1 < list_count; k++) list_keys[k] = list_keys[k+1];
        list_count--;
        res.status = ST_DONE;
      end
    end
    res.count = list_count[COUNT_W-1:0];
    return res;
  endfunction

  // Chooses the next random command. A filling phase favours inserts and a
  // draining phase favours deletes, so the store swings between empty and
  // full many times. Most deletes hit a live key, and a good share of the
  // inserts repeat small or existing keys so that runs of equal keys build up.
  task automatic pick_command(input bit filling, output action_t act,
                              output logic [WORD_W-1:0] key);
    int roll;
    roll = $urandom_range(0, 99);
    act  = (roll < (filling ? 75 : 25)) ? ACT_INSERT : ACT_DELETE;
    roll = $urandom_range(0, 99);
    key  = $urandom;
    if (act == ACT_DELETE) begin
      if (list_count > 0 && roll < 70) begin
        key = list_keys[$urandom_range(0, list_count - 1)];
      end else if (list_count > 0 && roll < 85) begin
        // A near miss: one above a live key, which may or may not be stored.
        key = list_keys[$urandom_range(0, list_count - 1)] + 1;
      end
    end else begin
      if (roll < 35) begin
        key = $urandom_range(0, 6) - 3;
      end else if (roll < 45) begin
        key = roll[0] ? 32'h7fff_ffff : 32'h8000_0000;
      end else if (list_count > 0 && roll < 60) begin
        key = list_keys[$urandom_range(0, list_count - 1)];
      end
    end
  endtask

  // Offers one command word and holds it until the core takes it. Words go out
  // in bursts of random length; between bursts the sender sometimes rests with
  // junk on the payload. The task is entered and left at a rising edge, and valid
  // is only lowered where a gap actually follows.
  task automatic send_word(input action_t act, input logic [WORD_W-1:0] key,
                           input logic has_result, input result_t typed);
    int      gap;
    result_t predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid  <= 1'b0;
        in_action <= 1'($urandom_range(0, 1));
        in_value  <= $urandom;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid  <= 1'b1;
    in_action <= act;
    in_value  <= key;
    // Valid is high at every edge from here on, so the first edge that finds
    // the stall low is the one at which the word is taken.
    do @(posedge clk); while (in_stall);
    predicted = apply_command(act, key);
    pending_results.push_back(has_result ? typed : predicted);
  endtask

  // Stimulus: reset, the directed rows, the random part, then the drain.
  initial begin : stimulus
    action_t             act;
    logic [WORD_W-1:0]   key;
    bit                  filling;
    filling = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].act, directed_rows[i].key, directed_rows[i].has_result,
                '{directed_rows[i].status, directed_rows[i].count});
    end

    // The directed part leaves the store nearly full, yet the random part
    // opens with a filling phase.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 48 == 0) filling = ~filling;
      pick_command(filling, act, key);
      send_word(act, key, 1'b0, '0);
    end
    in_valid <= 1'b0;

    // Wait for every owed result, then a little longer so that any stray
    // extra word from the core is caught by the receiver.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Receiver: checks each result word taken against the oldest prediction and
  // drives its own stall pattern. Every value read here is the one sampled at
  // the edge, since all driven signals change through nonblocking updates.
  always @(posedge clk) begin : receiver
    result_t            oldest;
    static stall_mode_t stall_mode = STALL_NONE;
    static int          stall_left = 0;
    static int          mode_age   = 0;

    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: result word with none owed: status %0d, count %0d",
                 $time, out_status, out_entry_count);
        mismatch_count++;
      end else begin
        oldest = pending_results.pop_front();
        if (out_status !== oldest.status) begin
          $display("%0t ns: status expected %0d, got %0d",
                   $time, oldest.status, out_status);
          mismatch_count++;
        end
        if (out_entry_count !== oldest.count) begin
          $display("%0t ns: entry count expected %0d, got %0d",
                   $time, oldest.count, out_entry_count);
          mismatch_count++;
        end
      end
    end

    // The stall pattern is redrawn each time mode_age runs out: sometimes
    // never stalling, sometimes scattering stalls at random, and
    // sometimes holding the core off for long stretches.
    mode_age++;
    if (mode_age >= 120) begin
      mode_age   = 0;
      stall_mode = stall_mode_t'($urandom_range(0, 2));
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_NONE: begin
          out_stall <= 1'b0;
        end
        STALL_SPRINKLE: begin
          out_stall <= ($urandom_range(0, 2) == 0);
        end
        default: begin
          if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(4, 30);
            out_stall <= 1'b1;
          end else begin
            out_stall <= 1'b0;
          end
        end
      endcase
    end
  end

  // Watchdog: counts cycles out of reset in which no word moves on either
  // channel, and gives up once the count reaches the limit.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t ns: no word moved for %0d cycles", $time, QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
